### rtl/lchs_pkg.sv
// shared types, constants and helpers for the lba to chs position block
`default_nettype none

package lchs_pkg;

    localparam int LBA_W   = 32;
    localparam int GEOM_W  = 8;
    localparam int STEP_W  = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register indexes
    localparam logic REG_HEAD_COUNT        = 1'b0;
    localparam logic REG_SECTORS_PER_TRACK = 1'b1;

    // function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // geometry as used by the datapath (zero forced to one)
    typedef struct packed {
        logic [GEOM_W-1:0] heads;
        logic [GEOM_W-1:0] spt;
    } geom_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

    function automatic logic [GEOM_W-1:0] eff_geom(input logic [GEOM_W-1:0] v);
        eff_geom = (v == '0) ? GEOM_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

### rtl/lchs_regs.sv
// apb configuration registers for head count and sectors per track
`default_nettype none

module lchs_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lchs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lchs_pkg::DATA_W-1:0]   pwdata,
    output logic      [lchs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output lchs_pkg::geom_t                    geom
);

    logic [lchs_pkg::GEOM_W-1:0] head_count_reg;
    logic [lchs_pkg::GEOM_W-1:0] spt_reg;
    logic                        wr_en;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_count_reg <= lchs_pkg::GEOM_W'(1);
            spt_reg        <= lchs_pkg::GEOM_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lchs_pkg::REG_HEAD_COUNT:        head_count_reg <= pwdata[lchs_pkg::GEOM_W-1:0];
                lchs_pkg::REG_SECTORS_PER_TRACK: spt_reg        <= pwdata[lchs_pkg::GEOM_W-1:0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lchs_pkg::REG_HEAD_COUNT:
                prdata = {{(lchs_pkg::DATA_W-lchs_pkg::GEOM_W){1'b0}}, head_count_reg};
            lchs_pkg::REG_SECTORS_PER_TRACK:
                prdata = {{(lchs_pkg::DATA_W-lchs_pkg::GEOM_W){1'b0}}, spt_reg};
            default:
                prdata = '0;
        endcase
    end

    assign geom.heads = lchs_pkg::eff_geom(head_count_reg);
    assign geom.spt   = lchs_pkg::eff_geom(spt_reg);

endmodule

`default_nettype wire

### rtl/lchs_divider.sv
// radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle
`default_nettype none

module lchs_divider
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lchs_pkg::div_ctrl_t           ctrl,
    input  wire logic [lchs_pkg::LBA_W-1:0]    dividend,
    input  wire logic [lchs_pkg::GEOM_W-1:0]   divisor,
    output lchs_pkg::div_stat_t                stat,
    output logic      [lchs_pkg::LBA_W-1:0]    quotient,
    output logic      [lchs_pkg::GEOM_W-1:0]   remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [lchs_pkg::STEP_W-1:0]   cnt_reg;
    logic [lchs_pkg::LBA_W-1:0]    quo_reg;
    logic [lchs_pkg::GEOM_W-1:0]   rem_reg;
    logic [lchs_pkg::GEOM_W-1:0]   div_reg;

    logic [lchs_pkg::GEOM_W:0]     shifted;
    logic [lchs_pkg::GEOM_W:0]     trial;
    logic                          ge;
    logic [lchs_pkg::GEOM_W-1:0]   rem_next;
    logic [lchs_pkg::LBA_W-1:0]    quo_next;

    // bring in the next dividend bit and try the subtract
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[lchs_pkg::LBA_W-1]};
        trial    = shifted - {1'b0, div_reg};
        ge       = (shifted >= {1'b0, div_reg});
        rem_next = ge ? trial[lchs_pkg::GEOM_W-1:0] : shifted[lchs_pkg::GEOM_W-1:0];
        quo_next = {quo_reg[lchs_pkg::LBA_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + lchs_pkg::STEP_W'(1);
                if (cnt_reg == {lchs_pkg::STEP_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/disk_lba_to_chs_position.sv
// top level: disk position keeper, lba to cylinder/head/sector with sector advance
// load: result after two passes through the shared bit-serial divider
//   (32 steps each), first lba / spt, then track / heads
// advance: result valid in the cycle after the input transaction, no divider use
// throughput: one advance per cycle, a load takes no new input until both passes end; input stalls
//   while a load is dividing or a result waits
// reset: rst_n asynchronous active low, position clears to zero, geometry to one
`default_nettype none

module disk_lba_to_chs_position
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input transaction
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          func,
    input  wire logic [lchs_pkg::LBA_W-1:0]    logical_block,
    // result transaction
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lchs_pkg::LBA_W-1:0]    cylinder,
    output logic      [lchs_pkg::GEOM_W-1:0]   head,
    output logic      [lchs_pkg::GEOM_W-1:0]   sector,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lchs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lchs_pkg::DATA_W-1:0]   pwdata,
    output logic      [lchs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    // sequencer states
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_DIV_SPT   = 2'd1;  // lba / spt in flight
    localparam logic [1:0] ST_DIV_HEADS = 2'd2;  // track / heads in flight

    lchs_pkg::geom_t               geom;
    lchs_pkg::div_ctrl_t           div_ctrl;
    lchs_pkg::div_stat_t           div_stat;
    logic [lchs_pkg::LBA_W-1:0]    div_dividend;
    logic [lchs_pkg::GEOM_W-1:0]   div_divisor;
    logic [lchs_pkg::LBA_W-1:0]    div_quo;
    logic [lchs_pkg::GEOM_W-1:0]   div_rem;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lchs_pkg::LBA_W-1:0]    cyl_reg;
    logic [lchs_pkg::LBA_W-1:0]    cyl_next;
    logic [lchs_pkg::GEOM_W-1:0]   head_reg;
    logic [lchs_pkg::GEOM_W-1:0]   head_next;
    logic [lchs_pkg::GEOM_W-1:0]   sec_reg;
    logic [lchs_pkg::GEOM_W-1:0]   sec_next;

    logic                          in_fire;
    logic                          out_fire;
    logic [lchs_pkg::GEOM_W:0]     sec_inc;
    logic [lchs_pkg::GEOM_W:0]     head_inc;

    lchs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    lchs_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // a new item only enters when idle and the result slot is free or draining
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    // next sector and head, 9 bits wide so the compare sees the carry
    assign sec_inc  = {1'b0, sec_reg}  + (lchs_pkg::GEOM_W+1)'(1);
    assign head_inc = {1'b0, head_reg} + (lchs_pkg::GEOM_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        cyl_next       = cyl_reg;
        head_next      = head_reg;
        sec_next       = sec_reg;
        div_ctrl.start = 1'b0;
        div_dividend   = logical_block;
        div_divisor    = geom.spt;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == lchs_pkg::FUNC_LOAD)
                    begin
                        // first pass: sector = lba mod spt, track = lba / spt
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV_SPT;
                    end
                    else
                    begin
                        // advance; >= so a position past shrunk geometry wraps too
                        out_valid_next = 1'b1;
                        if (sec_inc >= {1'b0, geom.spt})
                        begin
                            sec_next = '0;
                            if (head_inc >= {1'b0, geom.heads})
                            begin
                                head_next = '0;
                                cyl_next  = cyl_reg + lchs_pkg::LBA_W'(1);
                            end
                            else
                            begin
                                head_next = head_inc[lchs_pkg::GEOM_W-1:0];
                            end
                        end
                        else
                        begin
                            sec_next = sec_inc[lchs_pkg::GEOM_W-1:0];
                        end
                    end
                end
            end
            ST_DIV_SPT:
            begin
                if (div_stat.done)
                begin
                    // second pass: head = track mod heads, cylinder = track / heads
                    sec_next       = div_rem;
                    div_dividend   = div_quo;
                    div_divisor    = geom.heads;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV_HEADS;
                end
            end
            ST_DIV_HEADS:
            begin
                if (div_stat.done)
                begin
                    cyl_next       = div_quo;
                    head_next      = div_rem;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cyl_reg       <= '0;
            head_reg      <= '0;
            sec_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cyl_reg       <= cyl_next;
            head_reg      <= head_next;
            sec_reg       <= sec_next;
        end
    end

    // position registers double as the result register; they hold while a result waits
    assign out_valid = out_valid_reg;
    assign cylinder  = cyl_reg;
    assign head      = head_reg;
    assign sector    = sec_reg;

endmodule

`default_nettype wire

### sim/tb_disk_lba_to_chs_position.sv
// testbench for disk_lba_to_chs_position: directed and random load/advance traffic, scoreboarded
`timescale 1ns / 100ps

module tb_disk_lba_to_chs_position;

    // one input transaction as queued for the driver
    typedef struct {
        logic        func;
        logic [31:0] lba;
    } disk_cmd_t;

    // one expected position
    typedef struct {
        logic [31:0] cyl;
        logic [7:0]  head;
        logic [7:0]  sector;
    } chs_pos_t;

    // dut connections, all inputs known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic        func          = 1'b0;
    logic [31:0] logical_block = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [7:0]  sector;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // commands waiting to be sent, positions waiting to come back
    disk_cmd_t   pending_cmds[$];
    chs_pos_t    expected_chs[$];

    // shadow geometry registers (raw, as written) and tracked position
    logic [7:0]  cfg_heads     = 8'd1;
    logic [7:0]  cfg_spt       = 8'd1;
    logic [31:0] pos_cyl       = '0;
    logic [7:0]  pos_head      = '0;
    logic [7:0]  pos_sector    = '0;

    // idle percentages and long receiver hold requests
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned error_count   = 0;

    disk_lba_to_chs_position dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .logical_block (logical_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cylinder      (cylinder),
        .head          (head),
        .sector        (sector),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #50_000_000;
        $display("disk_lba_to_chs_position regression: fail");
        $finish;
    end

    // a zero geometry register behaves as one
    function automatic int unsigned used_geom(input logic [7:0] v);
        used_geom = (v == 8'd0) ? 1 : int'(v);
    endfunction

    // report a mismatch, capped so a broken block cannot flood the log
    function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        error_count++;
        if (error_count <= 100)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    endfunction

    // advance the tracked position by one accepted command and queue the result
    function automatic void track_position(input disk_cmd_t c);
        int unsigned heads_n;
        int unsigned spt_n;
        int unsigned next_s;
        int unsigned next_h;
        chs_pos_t    p;
        heads_n = used_geom(cfg_heads);
        spt_n   = used_geom(cfg_spt);
        if (c.func == lchs_pkg::FUNC_LOAD)
        begin
            pos_cyl    = c.lba / (heads_n * spt_n);
            pos_head   = 8'((c.lba / spt_n) % heads_n);
            pos_sector = 8'(c.lba % spt_n);
        end
        else
        begin
            // greater-or-equal so a position left beyond a shrunk geometry wraps too
            next_s = pos_sector + 1;
            if (next_s >= spt_n)
            begin
                next_s = 0;
                next_h = pos_head + 1;
                if (next_h >= heads_n)
                begin
                    next_h  = 0;
                    pos_cyl = pos_cyl + 32'd1;
                end
                pos_head = 8'(next_h);
            end
            pos_sector = 8'(next_s);
        end
        p.cyl    = pos_cyl;
        p.head   = pos_head;
        p.sector = pos_sector;
        expected_chs.push_back(p);
    endfunction

    // driver: holds the payload while stalled, otherwise offers the next command or idles
    always @(posedge clk)
    begin : feed_proc
        logic offer;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                track_position(pending_cmds[0]);
                pending_cmds.delete(0);
            end
            if (!in_valid || !in_stall)
            begin
                offer = (pending_cmds.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
                in_valid <= offer;
                if (offer)
                begin
                    func          <= pending_cmds[0].func;
                    logical_block <= pending_cmds[0].lba;
                end
            end
        end
    end

    // receiver stall: requested long holds first, then occasional bursts, then per-cycle idling
    always @(posedge clk)
    begin : stall_proc
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            // long hold: block fills up and must stall its input
            hold_served = hold_requests;
            hold_left   = 300;
            out_stall <= 1'b1;
        end
        else if (rx_idle_pct != 0 && $urandom_range(399) == 0)
        begin
            hold_left = $urandom_range(120, 40);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // monitor: every accepted result against the oldest expected position
    always @(posedge clk)
    begin : check_proc
        chs_pos_t exp_p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chs.size() == 0)
                note_mismatch("unexpected result transaction, cylinder", 32'hx, cylinder);
            else
            begin
                exp_p = expected_chs[0];
                expected_chs.delete(0);
                if (cylinder !== exp_p.cyl)
                    note_mismatch("cylinder", exp_p.cyl, cylinder);
                if (head !== exp_p.head)
                    note_mismatch("head", {24'd0, exp_p.head}, {24'd0, head});
                if (sector !== exp_p.sector)
                    note_mismatch("sector", {24'd0, exp_p.sector}, {24'd0, sector});
            end
        end
    end

    // queue one command for the driver (called off the rising edge)
    task automatic queue_cmd(input logic f, input logic [31:0] lba);
        disk_cmd_t c;
        c.func = f;
        c.lba  = lba;
        pending_cmds.push_back(c);
    endtask

    // sender pause: nothing pending and every expected result delivered
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_chs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write then readback of one geometry register
    task automatic set_register(input logic idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands at this edge
        if (idx == lchs_pkg::REG_HEAD_COUNT)
            cfg_heads = val;
        else
            cfg_spt = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, val})
            note_mismatch("register readback", {24'd0, val}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new geometry, only with the block idle; returns just after a falling edge
    task automatic program_geometry(input logic [7:0] heads_v, input logic [7:0] spt_v);
        wait_idle();
        set_register(lchs_pkg::REG_HEAD_COUNT, heads_v);
        set_register(lchs_pkg::REG_SECTORS_PER_TRACK, spt_v);
        @(negedge clk);
    endtask

    // geometry values: extremes, zero, mostly small so carries happen often
    function automatic logic [7:0] pick_geom();
        case ($urandom_range(9))
            0:       pick_geom = 8'd0;
            1:       pick_geom = 8'd255;
            2:       pick_geom = 8'd1;
            3, 4, 5, 6: pick_geom = 8'($urandom_range(8, 2));
            default: pick_geom = 8'($urandom_range(255, 1));
        endcase
    endfunction

    // logical addresses spread over the full range and around cylinder edges
    function automatic logic [31:0] pick_lba();
        int unsigned span;
        span = used_geom(cfg_heads) * used_geom(cfg_spt);
        case ($urandom_range(7))
            0:       pick_lba = 32'hFFFF_FFFF;
            1:       pick_lba = $urandom_range(3 * span, 0);
            2:       pick_lba = span * $urandom_range(1000, 1) - 1;
            3:       pick_lba = span * $urandom_range(1000, 0) + $urandom_range(span - 1, 0);
            4:       pick_lba = 32'd0;
            default: pick_lba = $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned mode;
        int unsigned blk;
        int unsigned n;
        int unsigned run;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset geometry of one head, one sector
        tx_idle_pct = 19;
        rx_idle_pct = 58;
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd0);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF);      // address ignored
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'hFFFF_FFFF);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'd0);              // cylinder wraps to zero

        // largest geometry, last sector of the first cylinder
        program_geometry(8'd255, 8'd255);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'hFFFF_FFFF);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd65024);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'h5A5A_5A5A);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd65024);

        // shrink under the held position: sector and head both out of range
        program_geometry(8'd2, 8'd3);
        repeat (7) queue_cmd(lchs_pkg::FUNC_ADVANCE, $urandom);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd5);

        // zero registers used as one
        program_geometry(8'd0, 8'd0);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'h1234_5678);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'hA5A5_A5A5);

        // one sector per track, head carries straight into cylinder
        program_geometry(8'd255, 8'd1);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd508);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'd0);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'd0);

        // one head, sector carries straight into cylinder
        program_geometry(8'd1, 8'd255);
        queue_cmd(lchs_pkg::FUNC_LOAD, 32'd254);
        queue_cmd(lchs_pkg::FUNC_ADVANCE, 32'd0);

        // random: three idling modes, six geometry settings each
        for (mode = 0; mode < 3; mode++)
        begin
            for (blk = 0; blk < 6; blk++)
            begin
                program_geometry(pick_geom(), pick_geom());
                case (mode)
                    0:
                    begin
                        tx_idle_pct = 19;
                        rx_idle_pct = 58;
                    end
                    1:
                    begin
                        tx_idle_pct = 58;
                        rx_idle_pct = 19;
                    end
                    default:
                    begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                // long receiver hold while the sender keeps offering
                if (blk == 1)
                    hold_requests++;
                n = 0;
                while (n < 100)
                begin
                    case ($urandom_range(9))
                        7, 8:
                        begin
                            // bare advances from wherever the position is
                            run = $urandom_range(8, 1);
                            repeat (run) queue_cmd(lchs_pkg::FUNC_ADVANCE, $urandom);
                            n += run;
                        end
                        9:
                        begin
                            queue_cmd(lchs_pkg::FUNC_LOAD, $urandom);
                            n++;
                        end
                        default:
                        begin
                            // load then a walk of sectors, random address on the walk
                            queue_cmd(lchs_pkg::FUNC_LOAD, pick_lba());
                            run = $urandom_range(12, 0);
                            repeat (run) queue_cmd(lchs_pkg::FUNC_ADVANCE, $urandom);
                            n += run + 1;
                        end
                    endcase
                end
            end
        end

        // drain, then allow for a full load latency before the verdict
        wait_idle();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("disk_lba_to_chs_position regression: pass");
        else
            $display("disk_lba_to_chs_position regression: fail");
        $finish;
    end

endmodule

### disk_lba_to_chs_position.f
rtl/lchs_pkg.sv
rtl/lchs_regs.sv
rtl/lchs_divider.sv
rtl/disk_lba_to_chs_position.sv
sim/tb_disk_lba_to_chs_position.sv
